>>> src/lspc_pkg.sv
// Shared decision reason codes for the load switch priority controller.
package lspc_pkg;

  localparam int unsigned ReasonWidth = 5;
  localparam int unsigned StepsWidth  = 4;

  typedef enum logic [ReasonWidth-1:0] {
    RS_PHYS       = 5'd0,
    RS_WEB        = 5'd1,
    RS_HELD       = 5'd2,
    RS_FT_ALREADY = 5'd3,
    RS_FT_START   = 5'd4,
    RS_FT_USED    = 5'd5,
    RS_FT_UNUSED  = 5'd6,
    RS_AWAY       = 5'd7,
    RS_BACK       = 5'd8,
    RS_G_INUSE    = 5'd9,
    RS_G_ISON     = 5'd10,
    RS_G_AWAY     = 5'd11,
    RS_G_USED     = 5'd12,
    RS_G_GO       = 5'd13,
    RS_G_NOTIMER  = 5'd14,
    RS_G_LOST     = 5'd15,
    RS_NONE       = 5'd16
  } reason_e;

  typedef struct packed {
    logic physical_primary;
    logic forced_primary;
    logic forced_used;
    logic green_primary;
    logic green_used;
  } marks_t;

endpackage

>>> src/load_switch_priority_controller.sv
// Top level of the load switch priority controller with its step sequencer.
//
// An item is accepted only while the block is idle. It then runs one to
// MAX_STEPS priority steps, set by the single shared decision unit that the
// sequencer applies until the relay is stable, and then loads the output
// register, which stalls while an earlier result has not been taken.
// The block is ready again on the cycle after the load. The result waits in
// the output register until it is taken, and a new item may be accepted
// meanwhile. Edges of the source levels count in the first step only, and
// step_limit_hit_o reports that the last allowed step still changed the relay.
module load_switch_priority_controller #(
  parameter int unsigned MAX_STEPS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       physical_level_i,
  input  logic       web_toggle_i,
  input  logic       forced_timer_level_i,
  input  logic       away_level_i,
  input  logic       green_timer_level_i,
  input  logic       excess_green_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       relay_on_o,
  output logic       changed_o,
  output logic [4:0] last_reason_o,
  output logic [3:0] steps_taken_o,
  output logic       step_limit_hit_o
);

  localparam int unsigned CntW = $clog2(MAX_STEPS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_PUT
  } state_e;

  state_e state_q;

  logic relay_q, before_q;
  logic lv_phys_q, lv_forced_q, lv_away_q, lv_gtimer_q, lv_excess_q;
  logic e_phys_q, e_web_q, e_forced_q, e_away_q, e_excess_q;
  lspc_pkg::marks_t marks_q, marks_d;
  logic [CntW-1:0] steps_q, steps_d;
  lspc_pkg::reason_e why_q, why_d;
  logic hit_q;
  logic relay_d;

  logic out_valid_q, out_relay_q, out_changed_q, out_hit_q;
  lspc_pkg::reason_e out_reason_q;
  logic [lspc_pkg::StepsWidth-1:0] out_steps_q;
  logic [CntW+lspc_pkg::StepsWidth-1:0] steps_ext;

  logic in_fire, out_fire, stable, at_limit, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_free   = !out_valid_q || out_ready_i;

  // One priority step over the stored levels, edges and marks.
  always_comb begin
    relay_d = relay_q;
    why_d   = lspc_pkg::RS_NONE;
    marks_d = marks_q;
    if (e_phys_q) begin
      marks_d.physical_primary = 1'b1;
      why_d   = lspc_pkg::RS_PHYS;
      relay_d = lv_phys_q;
    end else if (e_web_q) begin
      marks_d.physical_primary = 1'b0;
      marks_d.forced_primary   = 1'b0;
      marks_d.green_primary    = 1'b0;
      why_d   = lspc_pkg::RS_WEB;
      relay_d = !relay_q;
    end else if (relay_q && lv_phys_q && marks_q.physical_primary) begin
      why_d = lspc_pkg::RS_HELD;
    end else if (e_forced_q) begin
      if (lv_forced_q) begin
        if (relay_q) begin
          why_d = lspc_pkg::RS_FT_ALREADY;
        end else begin
          why_d = lspc_pkg::RS_FT_START;
          marks_d.physical_primary = 1'b0;
          marks_d.green_primary    = 1'b0;
          marks_d.forced_primary   = 1'b1;
          marks_d.forced_used      = 1'b1;
          relay_d = 1'b1;
        end
      end else if (marks_q.forced_used) begin
        why_d = lspc_pkg::RS_FT_USED;
        marks_d.forced_primary = 1'b0;
        relay_d = 1'b0;
      end else begin
        why_d = lspc_pkg::RS_FT_UNUSED;
      end
    end else if (e_away_q && lv_away_q && relay_q && marks_q.green_primary) begin
      why_d   = lspc_pkg::RS_AWAY;
      relay_d = 1'b0;
    end else if (e_away_q && !lv_away_q && !relay_q && marks_q.green_primary) begin
      why_d   = lspc_pkg::RS_BACK;
      relay_d = 1'b1;
    end else if (lv_excess_q && lv_gtimer_q) begin
      if (marks_q.green_primary) begin
        why_d = lspc_pkg::RS_G_INUSE;
      end else if (relay_q) begin
        why_d = lspc_pkg::RS_G_ISON;
        if (!marks_q.forced_primary) begin
          marks_d.green_used = 1'b1;
        end
      end else if (lv_away_q) begin
        why_d = lspc_pkg::RS_G_AWAY;
        marks_d.green_used = 1'b1;
      end else if (marks_q.green_used) begin
        why_d = lspc_pkg::RS_G_USED;
      end else begin
        why_d = lspc_pkg::RS_G_GO;
        marks_d.green_primary = 1'b1;
        marks_d.green_used    = 1'b1;
        relay_d = 1'b1;
      end
    end else if (marks_q.green_primary) begin
      why_d = lspc_pkg::RS_G_LOST;
      marks_d.green_used    = 1'b0;
      marks_d.green_primary = 1'b0;
      relay_d = 1'b0;
    end else if (e_excess_q && !lv_excess_q) begin
      marks_d.green_used    = 1'b0;
      marks_d.green_primary = 1'b0;
    end
  end

  assign steps_d   = steps_q + 1'b1;
  assign stable    = (relay_d == relay_q);
  assign at_limit  = (steps_d >= CntW'(MAX_STEPS));
  assign steps_ext = {{lspc_pkg::StepsWidth{1'b0}}, steps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      relay_q     <= 1'b0;
      lv_phys_q   <= 1'b0;
      lv_forced_q <= 1'b0;
      lv_away_q   <= 1'b0;
      lv_gtimer_q <= 1'b0;
      lv_excess_q <= 1'b0;
      e_phys_q    <= 1'b0;
      e_web_q     <= 1'b0;
      e_forced_q  <= 1'b0;
      e_away_q    <= 1'b0;
      e_excess_q  <= 1'b0;
      marks_q     <= '0;
      steps_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_PUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            e_phys_q    <= physical_level_i != lv_phys_q;
            e_web_q     <= web_toggle_i;
            e_forced_q  <= forced_timer_level_i != lv_forced_q;
            e_away_q    <= away_level_i != lv_away_q;
            e_excess_q  <= excess_green_level_i != lv_excess_q;
            lv_phys_q   <= physical_level_i;
            lv_forced_q <= forced_timer_level_i;
            lv_away_q   <= away_level_i;
            lv_gtimer_q <= green_timer_level_i;
            lv_excess_q <= excess_green_level_i;
            before_q    <= relay_q;
            steps_q     <= '0;
            hit_q       <= 1'b0;
            state_q     <= S_STEP;
          end
        end
        S_STEP: begin
          relay_q    <= relay_d;
          marks_q    <= marks_d;
          why_q      <= why_d;
          steps_q    <= steps_d;
          e_phys_q   <= 1'b0;
          e_web_q    <= 1'b0;
          e_forced_q <= 1'b0;
          e_away_q   <= 1'b0;
          e_excess_q <= 1'b0;
          if (stable) begin
            state_q <= S_PUT;
          end else if (at_limit) begin
            hit_q   <= 1'b1;
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_relay_q   <= relay_q;
            out_changed_q <= relay_q != before_q;
            out_reason_q  <= why_q;
            out_steps_q   <= steps_ext[lspc_pkg::StepsWidth-1:0];
            out_hit_q     <= hit_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign relay_on_o       = out_relay_q;
  assign changed_o        = out_changed_q;
  assign last_reason_o    = out_reason_q;
  assign steps_taken_o    = out_steps_q;
  assign step_limit_hit_o = out_hit_q;

  a_steps_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (steps_q < CntW'(MAX_STEPS)))
    else $error("Step counter ran past the limit.");

  a_edges_first_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |=>
      !(e_phys_q || e_web_q || e_forced_q || e_away_q || e_excess_q))
    else $error("Edges survived the first step.");

  a_limit_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && step_limit_hit_o) |-> (out_reason_q != lspc_pkg::RS_NONE))
    else $error("Step limit reported on a step that cannot change the relay.");

  a_load_from_put : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_PUT))
    else $error("Result item loaded outside the output state.");

endmodule

>>> test/load_switch_priority_controller_checker.sv
`timescale 1ns / 100ps
// Checker that predicts each relay decision and compares it with the block's results.
module load_switch_priority_controller_checker #(
  parameter int unsigned MAX_STEPS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       physical_level_i,
  input  logic       web_toggle_i,
  input  logic       forced_timer_level_i,
  input  logic       away_level_i,
  input  logic       green_timer_level_i,
  input  logic       excess_green_level_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       relay_on_i,
  input  logic       changed_i,
  input  logic [4:0] last_reason_i,
  input  logic [3:0] steps_taken_i,
  input  logic       step_limit_hit_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic                                  relay_on;
    logic                                  changed;
    logic [lspc_pkg::ReasonWidth-1:0]      last_reason;
    logic [lspc_pkg::StepsWidth-1:0]       steps_taken;
    logic                                  step_limit_hit;
  } relay_result_t;

  relay_result_t expected_q[$];

  int               fail_count = 0;
  int               pending = 0;
  logic             relay_q;
  logic             lvl_phys, lvl_forced, lvl_away, lvl_gtimer, lvl_excess;
  lspc_pkg::marks_t marks;
  logic             edge_phys, edge_web, edge_forced, edge_away, edge_excess;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic clear_primaries();
    marks.physical_primary = 1'b0;
    marks.forced_primary   = 1'b0;
    marks.green_primary    = 1'b0;
  endtask

  // One priority step, highest priority first.
  task automatic apply_rule(output logic nxt, output lspc_pkg::reason_e why);
    logic s;
    s   = relay_q;
    nxt = s;
    why = lspc_pkg::RS_NONE;
    if (edge_phys) begin
      marks.physical_primary = 1'b1;
      why = lspc_pkg::RS_PHYS;
      nxt = lvl_phys;
    end else if (edge_web) begin
      clear_primaries();
      why = lspc_pkg::RS_WEB;
      nxt = !s;
    end else if (s && lvl_phys && marks.physical_primary) begin
      why = lspc_pkg::RS_HELD;
    end else if (edge_forced) begin
      if (lvl_forced) begin
        if (s) begin
          why = lspc_pkg::RS_FT_ALREADY;
        end else begin
          why = lspc_pkg::RS_FT_START;
          clear_primaries();
          marks.forced_primary = 1'b1;
          marks.forced_used    = 1'b1;
          nxt = 1'b1;
        end
      end else if (marks.forced_used) begin
        why = lspc_pkg::RS_FT_USED;
        marks.forced_primary = 1'b0;
        nxt = 1'b0;
      end else begin
        why = lspc_pkg::RS_FT_UNUSED;
      end
    end else if (edge_away && lvl_away && s && marks.green_primary) begin
      why = lspc_pkg::RS_AWAY;
      nxt = 1'b0;
    end else if (edge_away && !lvl_away && !s && marks.green_primary) begin
      why = lspc_pkg::RS_BACK;
      nxt = 1'b1;
    end else if (lvl_excess && lvl_gtimer) begin
      if (marks.green_primary) begin
        why = lspc_pkg::RS_G_INUSE;
      end else if (s) begin
        why = lspc_pkg::RS_G_ISON;
        if (!marks.forced_primary) marks.green_used = 1'b1;
      end else if (lvl_away) begin
        why = lspc_pkg::RS_G_AWAY;
        marks.green_used = 1'b1;
      end else if (marks.green_used) begin
        why = lspc_pkg::RS_G_USED;
      end else begin
        marks.green_primary = 1'b1;
        marks.green_used    = 1'b1;
        why = lspc_pkg::RS_G_GO;
        nxt = 1'b1;
      end
    end else if (marks.green_primary) begin
      why = lspc_pkg::RS_G_LOST;
      marks.green_used    = 1'b0;
      marks.green_primary = 1'b0;
      nxt = 1'b0;
    end else if (edge_excess && !lvl_excess) begin
      marks.green_used    = 1'b0;
      marks.green_primary = 1'b0;
    end
  endtask

  task automatic predict_relay(input logic p, input logic w, input logic f, input logic a,
                               input logic g, input logic x, output relay_result_t res);
    logic              before_relay, old_relay, nxt, hit, done;
    lspc_pkg::reason_e why;
    int unsigned       steps;
    before_relay = relay_q;
    edge_phys    = (p != lvl_phys);
    edge_web     = w;
    edge_forced  = (f != lvl_forced);
    edge_away    = (a != lvl_away);
    edge_excess  = (x != lvl_excess);
    lvl_phys     = p;
    lvl_forced   = f;
    lvl_away     = a;
    lvl_gtimer   = g;
    lvl_excess   = x;
    steps        = 0;
    hit          = 1'b0;
    done         = 1'b0;
    why          = lspc_pkg::RS_NONE;
    while (!done) begin
      old_relay = relay_q;
      apply_rule(nxt, why);
      relay_q     = nxt;
      edge_phys   = 1'b0;
      edge_web    = 1'b0;
      edge_forced = 1'b0;
      edge_away   = 1'b0;
      edge_excess = 1'b0;
      steps++;
      if (old_relay == relay_q) begin
        done = 1'b1;
      end else if (steps >= MAX_STEPS) begin
        hit  = 1'b1;
        done = 1'b1;
      end
    end
    res.relay_on       = relay_q;
    res.changed        = (relay_q != before_relay);
    res.last_reason    = why;
    res.steps_taken    = steps[lspc_pkg::StepsWidth-1:0];
    res.step_limit_hit = hit;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    relay_result_t exp_r;
    if (!rst_ni) begin
      relay_q     = 1'b0;
      lvl_phys    = 1'b0;
      lvl_forced  = 1'b0;
      lvl_away    = 1'b0;
      lvl_gtimer  = 1'b0;
      lvl_excess  = 1'b0;
      marks       = '0;
      edge_phys   = 1'b0;
      edge_web    = 1'b0;
      edge_forced = 1'b0;
      edge_away   = 1'b0;
      edge_excess = 1'b0;
      expected_q.delete();
      pending     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item waiting, expected none actual relay_on %0d",
                   $time, relay_on_i);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("relay_on", 32'(exp_r.relay_on), 32'(relay_on_i));
          check_field("changed", 32'(exp_r.changed), 32'(changed_i));
          check_field("last_reason", 32'(exp_r.last_reason), 32'(last_reason_i));
          check_field("steps_taken", 32'(exp_r.steps_taken), 32'(steps_taken_i));
          check_field("step_limit_hit", 32'(exp_r.step_limit_hit),
                      32'(step_limit_hit_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_relay(physical_level_i, web_toggle_i, forced_timer_level_i, away_level_i,
                      green_timer_level_i, excess_green_level_i, exp_r);
        expected_q.push_back(exp_r);
      end
      pending = expected_q.size();
    end
  end

endmodule

>>> test/load_switch_priority_controller_tb.sv
`timescale 1ns / 100ps
// Testbench top that drives relay request items into the controller and reports the verdict.
module load_switch_priority_controller_tb;

  localparam int unsigned MaxSteps   = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 400;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       physical_level = 1'b0;
  logic       web_toggle = 1'b0;
  logic       forced_timer_level = 1'b0;
  logic       away_level = 1'b0;
  logic       green_timer_level = 1'b0;
  logic       excess_green_level = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       relay_on;
  logic       changed;
  logic [4:0] last_reason;
  logic [3:0] steps_taken;
  logic       step_limit_hit;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 69;
  logic [5:0]  last_levels = '0;

  // Item bits: physical, web, forced timer, away, green timer, excess green.
  logic [5:0] directed_items [25] = '{
    6'b000000, 6'b100000, 6'b101000, 6'b001000, 6'b011000,
    6'b011000, 6'b000000, 6'b001000, 6'b011000, 6'b000000,
    6'b010000, 6'b001000, 6'b011000, 6'b000000, 6'b000011,
    6'b000111, 6'b000011, 6'b000010, 6'b000011, 6'b010011,
    6'b000000, 6'b000111, 6'b010011, 6'b111111, 6'b000000
  };

  load_switch_priority_controller #(
    .MAX_STEPS(MaxSteps)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .physical_level_i     (physical_level),
    .web_toggle_i         (web_toggle),
    .forced_timer_level_i (forced_timer_level),
    .away_level_i         (away_level),
    .green_timer_level_i  (green_timer_level),
    .excess_green_level_i (excess_green_level),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .relay_on_o           (relay_on),
    .changed_o            (changed),
    .last_reason_o        (last_reason),
    .steps_taken_o        (steps_taken),
    .step_limit_hit_o     (step_limit_hit)
  );

  load_switch_priority_controller_checker #(
    .MAX_STEPS(MaxSteps)
  ) checker_i (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .physical_level_i     (physical_level),
    .web_toggle_i         (web_toggle),
    .forced_timer_level_i (forced_timer_level),
    .away_level_i         (away_level),
    .green_timer_level_i  (green_timer_level),
    .excess_green_level_i (excess_green_level),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .relay_on_i           (relay_on),
    .changed_i            (changed),
    .last_reason_i        (last_reason),
    .steps_taken_i        (steps_taken),
    .step_limit_hit_i     (step_limit_hit),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [5:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid           <= 1'b1;
    physical_level     <= bits[5];
    web_toggle         <= bits[4];
    forced_timer_level <= bits[3];
    away_level         <= bits[2];
    green_timer_level  <= bits[1];
    excess_green_level <= bits[0];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned count);
    logic [5:0] item;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        item = 6'($urandom);
      end else begin
        item = last_levels;
        for (int b = 0; b < 6; b++) begin
          if (b != 4 && $urandom_range(3) == 0) item[b] = !item[b];
        end
        item[4] = ($urandom_range(99) < 15);
      end
      last_levels = item;
      send_item(item);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_items[i]) send_item(directed_items[i]);
    last_levels = directed_items[24];
    drain_results();

    run_random_phase(PhaseItems);
    drain_results();

    send_idle_pct = 69;
    recv_idle_pct = 19;
    run_random_phase(PhaseItems);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(PhaseItems);
    drain_results();

    repeat (4 * MaxSteps) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
